// ===== src/tcw_pkg.sv =====
package tcw_pkg;

	// Default geometry
	localparam int ROWS_DEF     = 25;
	localparam int COLUMNS_DEF  = 80;
	localparam int TAB_STEP_DEF = 8;

	// Fixed field widths
	localparam int ROW_FIELD_W  = 5;
	localparam int COL_FIELD_W  = 7;
	localparam int HWC_W        = 11;
	localparam int CELL_W       = 16;
	localparam int ATTR_W       = 8;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 8;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_ATTR  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_ATTR = 1'b1;

	// Register reset values
	localparam logic [ATTR_W-1:0] TEXT_ATTR_RST  = 8'd37;
	localparam logic [ATTR_W-1:0] BLANK_ATTR_RST = 8'd15;

	// Operations
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Control characters
	localparam logic [7:0] CHAR_BS    = 8'd8;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_LF    = 8'd10;
	localparam logic [7:0] CHAR_FF    = 8'd12;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Cell value after reset: default blank attribute with a space
	localparam logic [CELL_W-1:0] CELL_RST = {BLANK_ATTR_RST, CHAR_SPACE};

	typedef struct packed {
		logic       operation;
		logic [7:0] char_code;
		logic       end_of_string;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} tcw_in_t;

	typedef struct packed {
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_column;
		logic [10:0] cursor_register;
		logic [15:0] cell_value;
	} tcw_out_t;

	// What a put byte asks of the store
	typedef struct packed {
		logic write_glyph;
		logic clear;
		logic scroll;
	} tcw_step_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_SCROLL,
		S_FILL
	} tcw_state_t;

endpackage

// ===== src/tcw_cursor_step.sv =====
module tcw_cursor_step
	import tcw_pkg::*;
#(
	parameter int ROWS     = ROWS_DEF,
	parameter int COLUMNS  = COLUMNS_DEF,
	parameter int TAB_STEP = TAB_STEP_DEF,
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1,
	localparam int CW = $clog2(COLUMNS)
) (
	input  logic [RW-1:0] row,
	input  logic [CW-1:0] col,
	input  logic [7:0]    char_code,
	output tcw_step_t     step,
	output logic [RW-1:0] next_row,
	output logic [CW-1:0] next_col
);

	logic [RW:0] row_inc;
	logic [RW:0] row_n;
	logic [CW:0] col_inc;
	logic [CW:0] col_tab;
	logic [CW-1:0] col_n;
	logic glyph;
	logic clr;

	assign row_inc = {1'b0, row} + (RW+1)'(1);
	assign col_inc = {1'b0, col} + (CW+1)'(1);
	assign col_tab = {1'b0, col} + (CW+1)'(TAB_STEP);

	// Cursor move per byte
	always_comb begin
		row_n = {1'b0, row};
		col_n = col;
		glyph = 1'b0;
		clr   = 1'b0;
		case (char_code)
			CHAR_BS: begin
				if (col != '0) col_n = col - CW'(1);
			end
			CHAR_CR: begin
				col_n = '0;
			end
			CHAR_LF: begin
				row_n = row_inc;
				col_n = '0;
			end
			CHAR_TAB: begin
				// sum stays below twice the row length: one subtract wraps it
				if (col_tab >= (CW+1)'(COLUMNS)) begin
					row_n = row_inc;
					col_n = CW'(col_tab - (CW+1)'(COLUMNS));
				end else begin
					col_n = CW'(col_tab);
				end
			end
			CHAR_FF: begin
				clr   = 1'b1;
				row_n = '0;
				col_n = '0;
			end
			default: begin
				glyph = 1'b1;
				if (col_inc >= (CW+1)'(COLUMNS)) begin
					col_n = '0;
					row_n = row_inc;
				end else begin
					col_n = CW'(col_inc);
				end
			end
		endcase
	end

	// Past the last row: scroll and stay on the last row
	always_comb begin
		step.write_glyph = glyph;
		step.clear       = clr;
		step.scroll      = (row_n >= (RW+1)'(ROWS));
		next_row         = step.scroll ? RW'(ROWS - 1) : RW'(row_n);
		next_col         = col_n;
	end

endmodule

// ===== src/text_console_writer_unit.sv =====
// Channel   Signals                                   Direction  Word
// -------   ----------------------------------------  ---------  --------------------------
// item      start, busy, item                         in         operation, byte, read cell
// result    done, result                              out        cursor, hw cursor, cell
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in         attribute registers
//
// A plain put (no scroll, no form feed) is registered; its result shows the next cycle and a
// new item may be taken while it shows. A read waits in S_READ for the registered memory read.
// A scroll copies the cell memory row-up through its single write port, then blanks the
// last row; form feed writes every cell.
// After reset a clearing pass over every cell runs with busy high;
// configuration writes are taken throughout. The result receiver cannot stall.
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int ROWS     = ROWS_DEF,
	parameter int COLUMNS  = COLUMNS_DEF,
	parameter int TAB_STEP = TAB_STEP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  tcw_in_t                item,
	output logic                   done,
	output tcw_out_t               result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW    = $clog2(COLUMNS);
	localparam logic [AW-1:0] LAST_CELL   = AW'(CELLS - 1);
	localparam logic [AW-1:0] LAST_COPY   = AW'(CELLS - COLUMNS - 1);
	localparam logic [AW-1:0] COPY_LIMIT  = AW'(CELLS - COLUMNS);

	// Cell memory
	logic [CELL_W-1:0] cells [CELLS];
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata_q;

	// Control and cursor state
	tcw_state_t        state_q, state_d;
	logic [AW-1:0]     sweep_q;
	logic              pend_q;
	logic              copy_vld_s1;
	logic [AW-1:0]     copy_addr_s1;
	logic [RW-1:0]     row_q;
	logic [CW-1:0]     col_q;
	logic [HWC_W-1:0]  hwc_q;
	logic [ATTR_W-1:0] text_attr_q;
	logic [ATTR_W-1:0] blank_attr_q;
	logic              oob_q;
	logic              done_q;
	tcw_out_t          result_q;

	logic              accept;
	logic              is_put;
	tcw_step_t         step;
	logic [RW-1:0]     next_row;
	logic [CW-1:0]     next_col;
	logic [AW-1:0]     cur_addr;
	logic [AW-1:0]     next_lin;
	logic              rd_in_range;
	logic [AW-1:0]     rd_addr;
	logic [CELL_W-1:0] blank_cell;
	logic              sweep_end;

	tcw_cursor_step #(
		.ROWS     (ROWS),
		.COLUMNS  (COLUMNS),
		.TAB_STEP (TAB_STEP)
	) u_step (
		.row       (row_q),
		.col       (col_q),
		.char_code (item.char_code),
		.step      (step),
		.next_row  (next_row),
		.next_col  (next_col)
	);

	assign accept     = start && !busy;
	assign is_put     = (item.operation == OP_PUT);
	assign cur_addr   = AW'(32'(row_q) * COLUMNS + 32'(col_q));
	assign next_lin   = AW'(32'(next_row) * COLUMNS + 32'(next_col));
	assign rd_in_range = (32'(item.read_row) < ROWS) && (32'(item.read_column) < COLUMNS);
	assign rd_addr    = rd_in_range ?
		AW'(32'(item.read_row) * COLUMNS + 32'(item.read_column)) : '0;
	// reset pass uses the reset blank; form feed and scroll fill use the register
	assign blank_cell = (state_q == S_CLEAR && !pend_q) ? CELL_RST : {blank_attr_q, CHAR_SPACE};
	assign sweep_end  = (sweep_q == LAST_CELL);

	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sweep_end) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					if (!is_put)          state_d = S_READ;
					else if (step.clear)  state_d = S_CLEAR;
					else if (step.scroll) state_d = S_SCROLL;
				end
			end
			S_READ: begin
				state_d = S_IDLE;
			end
			S_SCROLL: begin
				if (sweep_q == LAST_COPY) state_d = S_FILL;
			end
			S_FILL: begin
				if (!copy_vld_s1 && sweep_end) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Memory port control; copy reads run COLUMNS ahead of their writes, so a
	// read never meets a cell that the copy has already moved
	always_comb begin
		busy      = (state_q != S_IDLE);
		mem_we    = 1'b0;
		mem_waddr = sweep_q;
		mem_wdata = blank_cell;
		mem_raddr = rd_addr;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_IDLE: begin
				mem_we    = accept && is_put && step.write_glyph;
				mem_waddr = cur_addr;
				mem_wdata = {text_attr_q, item.char_code};
			end
			S_SCROLL, S_FILL: begin
				mem_raddr = AW'(32'(sweep_q) + COLUMNS);
				mem_we    = 1'b1;
				if (copy_vld_s1) begin
					mem_waddr = copy_addr_s1;
					mem_wdata = mem_rdata_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Cell memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) cells[mem_waddr] <= mem_wdata;
		mem_rdata_q <= cells[mem_raddr];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			sweep_q     <= '0;
			pend_q      <= 1'b0;
			copy_vld_s1 <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			hwc_q       <= '0;
			text_attr_q <= TEXT_ATTR_RST;
			blank_attr_q <= BLANK_ATTR_RST;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			copy_vld_s1 <= (state_q == S_SCROLL);

			// attribute registers
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TEXT_ATTR:  text_attr_q  <= cfg_data;
					CFG_BLANK_ATTR: blank_attr_q <= cfg_data;
					default: ;
				endcase
			end

			// sweep counter
			case (state_q)
				S_IDLE: sweep_q <= '0;
				S_CLEAR, S_SCROLL: sweep_q <= AW'(32'(sweep_q) + 1);
				S_FILL: begin
					if (!copy_vld_s1) sweep_q <= AW'(32'(sweep_q) + 1);
				end
				default: sweep_q <= sweep_q;
			endcase

			// result strobe: plain put, read, end of scroll, end of form feed
			done_q <= (accept && is_put && !step.clear && !step.scroll) ||
				(state_q == S_READ) ||
				(state_q == S_FILL && !copy_vld_s1 && sweep_end) ||
				(state_q == S_CLEAR && sweep_end && pend_q);

			// cursor update
			if (accept && is_put) begin
				row_q <= next_row;
				col_q <= next_col;
				if (item.end_of_string) hwc_q <= HWC_W'(next_lin);
				if (step.clear) pend_q <= 1'b1;
			end
			if (state_q == S_CLEAR && sweep_end) pend_q <= 1'b0;
		end
	end

	// Result word and copy pipeline payload
	always_ff @(posedge clk) begin
		copy_addr_s1 <= sweep_q;
		if (accept) begin
			oob_q <= !rd_in_range;
			result_q.cursor_row    <= is_put ? ROW_FIELD_W'(next_row) : ROW_FIELD_W'(row_q);
			result_q.cursor_column <= is_put ? COL_FIELD_W'(next_col) : COL_FIELD_W'(col_q);
			result_q.cursor_register <= (is_put && item.end_of_string) ?
				HWC_W'(next_lin) : hwc_q;
			result_q.cell_value <= '0;
		end
		if (state_q == S_READ) result_q.cell_value <= oob_q ? '0 : mem_rdata_q;
	end

	// Checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe outside idle");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
		else $error("cursor out of range");

	a_copy_target: assert property (@(posedge clk) disable iff (!arst_n)
		copy_vld_s1 |-> (copy_addr_s1 < COPY_LIMIT))
		else $error("scroll copy writes into last row");

	a_hwc_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(hwc_q) |-> $past(accept && is_put && item.end_of_string))
		else $error("hardware cursor changed without end of string");

endmodule

// ===== verif/tb_text_console_writer_unit.sv =====
`timescale 1ns / 100ps

module tb_text_console_writer_unit;
	import tcw_pkg::*;

	localparam int ROWS  = ROWS_DEF;
	localparam int COLS  = COLUMNS_DEF;
	localparam int TAB   = TAB_STEP_DEF;
	localparam int CELLS = ROWS * COLS;

	// Directed stimulus row: item fields, repeat count, optional fixed expectation
	typedef struct packed {
		logic       op;
		logic [7:0] chr;
		logic       eos;
		logic [4:0] rr;
		logic [6:0] rc;
		logic [5:0] reps;
		logic       fixed;
		tcw_out_t   want;
	} step_row_t;

	localparam step_row_t PLAN [24] = '{
		'{OP_READ, 8'h00,      1'b0, 5'd0,  7'd0,   6'd1,  1'b1, {5'd0, 7'd0, 11'd0, 16'h0F20}},
		'{OP_READ, 8'h00,      1'b0, 5'd24, 7'd79,  6'd1,  1'b1, {5'd0, 7'd0, 11'd0, 16'h0F20}},
		'{OP_READ, 8'hFF,      1'b1, 5'd31, 7'd127, 6'd1,  1'b1, {5'd0, 7'd0, 11'd0, 16'h0000}},
		'{OP_READ, 8'h00,      1'b0, 5'd25, 7'd0,   6'd1,  1'b1, {5'd0, 7'd0, 11'd0, 16'h0000}},
		'{OP_READ, 8'h00,      1'b0, 5'd0,  7'd80,  6'd1,  1'b1, {5'd0, 7'd0, 11'd0, 16'h0000}},
		'{OP_PUT,  8'h41,      1'b1, 5'd31, 7'd127, 6'd1,  1'b1, {5'd0, 7'd1, 11'd1, 16'h0000}},
		'{OP_READ, 8'h00,      1'b0, 5'd0,  7'd0,   6'd1,  1'b1, {5'd0, 7'd1, 11'd1, 16'h2541}},
		'{OP_PUT,  CHAR_BS,    1'b0, 5'd0,  7'd0,   6'd1,  1'b1, {5'd0, 7'd0, 11'd1, 16'h0000}},
		'{OP_PUT,  CHAR_BS,    1'b1, 5'd0,  7'd0,   6'd1,  1'b1, {5'd0, 7'd0, 11'd0, 16'h0000}},
		'{OP_READ, 8'h00,      1'b0, 5'd0,  7'd0,   6'd1,  1'b1, {5'd0, 7'd0, 11'd0, 16'h2541}},
		'{OP_PUT,  8'hFF,      1'b0, 5'd0,  7'd0,   6'd1,  1'b0, '0},
		'{OP_PUT,  8'h00,      1'b0, 5'd0,  7'd0,   6'd1,  1'b0, '0},
		'{OP_PUT,  CHAR_CR,    1'b1, 5'd0,  7'd0,   6'd1,  1'b1, {5'd0, 7'd0, 11'd0, 16'h0000}},
		'{OP_PUT,  CHAR_TAB,   1'b0, 5'd0,  7'd0,   6'd9,  1'b0, '0},
		'{OP_PUT,  8'h7E,      1'b0, 5'd0,  7'd0,   6'd7,  1'b0, '0},
		'{OP_PUT,  8'h80,      1'b1, 5'd0,  7'd0,   6'd1,  1'b0, '0},
		'{OP_PUT,  CHAR_TAB,   1'b0, 5'd0,  7'd0,   6'd9,  1'b0, '0},
		'{OP_PUT,  8'h31,      1'b0, 5'd0,  7'd0,   6'd3,  1'b0, '0},
		'{OP_PUT,  CHAR_TAB,   1'b1, 5'd0,  7'd0,   6'd1,  1'b0, '0},
		'{OP_PUT,  CHAR_LF,    1'b1, 5'd0,  7'd0,   6'd24, 1'b0, '0},
		'{OP_READ, 8'h00,      1'b0, 5'd24, 7'd79,  6'd1,  1'b0, '0},
		'{OP_READ, 8'h00,      1'b0, 5'd21, 7'd0,   6'd1,  1'b0, '0},
		'{OP_PUT,  CHAR_FF,    1'b1, 5'd0,  7'd0,   6'd1,  1'b1, {5'd0, 7'd0, 11'd0, 16'h0000}},
		'{OP_READ, 8'h00,      1'b0, 5'd24, 7'd79,  6'd1,  1'b1, {5'd0, 7'd0, 11'd0, 16'h0F20}}
	};

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   start     = 1'b0;
	logic                   busy;
	tcw_in_t                item      = '0;
	logic                   done;
	tcw_out_t               result;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_TEXT_ATTR;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// Console mirror: cells, cursor, hw cursor, attributes
	logic [15:0]  mirror_cells [CELLS];
	int unsigned  cur_row = 0;
	int unsigned  cur_col = 0;
	logic [10:0]  mirror_hwc = '0;
	logic [7:0]   mirror_text_attr  = TEXT_ATTR_RST;
	logic [7:0]   mirror_blank_attr = BLANK_ATTR_RST;

	tcw_out_t     console_due [$];
	int unsigned  items_sent = 0;
	int unsigned  sender_gap_pct = 0;
	int unsigned  fail_count = 0;

	text_console_writer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void blank_span(int from, int to);
		for (int i = from; i < to; i++)
			mirror_cells[i] = {mirror_blank_attr, CHAR_SPACE};
	endfunction

	// One put byte against the mirror, scroll included
	function automatic void mirror_put(logic [7:0] c);
		case (c)
			CHAR_BS: begin
				if (cur_col > 0)
					cur_col--;
			end
			CHAR_CR: cur_col = 0;
			CHAR_LF: begin
				cur_row++;
				cur_col = 0;
			end
			CHAR_TAB: begin
				if (cur_col + TAB >= COLS) begin
					cur_row++;
					cur_col = (cur_col + TAB) % COLS;
				end else begin
					cur_col += TAB;
				end
			end
			CHAR_FF: begin
				blank_span(0, CELLS);
				cur_row = 0;
				cur_col = 0;
			end
			default: begin
				mirror_cells[cur_row * COLS + cur_col] = {mirror_text_attr, c};
				cur_col++;
				if (cur_col >= COLS) begin
					cur_col = 0;
					cur_row++;
				end
			end
		endcase
		// below the last row: shift up one row, blank the bottom
		if (cur_row >= ROWS) begin
			for (int i = 0; i + COLS < CELLS; i++)
				mirror_cells[i] = mirror_cells[i + COLS];
			blank_span(CELLS - COLS, CELLS);
			cur_row = ROWS - 1;
		end
	endfunction

	function automatic tcw_out_t console_step(tcw_in_t it);
		tcw_out_t    w;
		logic [15:0] cell_word;
		cell_word = '0;
		if (it.operation == OP_PUT) begin
			mirror_put(it.char_code);
			if (it.end_of_string)
				mirror_hwc = 11'(cur_row * COLS + cur_col);
		end else if (it.read_row < ROWS && it.read_column < COLS) begin
			cell_word = mirror_cells[it.read_row * COLS + it.read_column];
		end
		w.cursor_row      = 5'(cur_row);
		w.cursor_column   = 7'(cur_col);
		w.cursor_register = mirror_hwc;
		w.cell_value      = cell_word;
		return w;
	endfunction

	function automatic tcw_in_t put_word(logic [7:0] c, logic eos);
		tcw_in_t it;
		it.operation     = OP_PUT;
		it.char_code     = c;
		it.end_of_string = eos;
		it.read_row      = 5'($urandom_range(31));
		it.read_column   = 7'($urandom_range(127));
		return it;
	endfunction

	// Present one word, hold until taken, then queue what it should return
	task automatic send_item(tcw_in_t it, bit use_fixed = 1'b0, tcw_out_t fixed_word = '0);
		tcw_out_t w;
		while ($urandom_range(99) < sender_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		w = console_step(it);
		console_due.push_back(use_fixed ? fixed_word : w);
		items_sent++;
	endtask

	// Hold off until every word is back and the block is idle
	task automatic settle();
		start <= 1'b0;
		while (console_due.size() != 0)
			@(posedge clk);
		do @(posedge clk); while (busy);
	endtask

	task automatic load_attrs(logic [7:0] text_val, logic [7:0] blank_val);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TEXT_ATTR;
		cfg_data  <= text_val;
		do @(posedge clk); while (!cfg_ready);
		mirror_text_attr = text_val;
		cfg_index <= CFG_BLANK_ATTR;
		cfg_data  <= blank_val;
		do @(posedge clk); while (!cfg_ready);
		mirror_blank_attr = blank_val;
		cfg_valid <= 1'b0;
	endtask

	// One burst of related words: text lines, line feeds, cursor moves, reads, form feed, random words or attribute load
	task automatic emit_burst();
		int unsigned pick;
		int unsigned len;
		tcw_in_t     it;
		logic [7:0]  c;
		pick = $urandom_range(99);
		if (pick < 45) begin
			len = $urandom_range(24, 1);
			for (int k = 0; k < len; k++)
				send_item(put_word(8'($urandom_range(255)), $urandom_range(19) == 0));
			case ($urandom_range(3))
				0: begin
					send_item(put_word(CHAR_CR, 1'b0));
					send_item(put_word(CHAR_LF, 1'b1));
				end
				1: send_item(put_word(CHAR_LF, 1'b1));
				default: send_item(put_word(8'($urandom_range(126, 33)), 1'b1));
			endcase
		end else if (pick < 55) begin
			len = $urandom_range(6, 1);
			for (int k = 0; k < len; k++)
				send_item(put_word(CHAR_LF, k == len - 1));
		end else if (pick < 70) begin
			len = $urandom_range(12, 1);
			for (int k = 0; k < len; k++) begin
				case ($urandom_range(3))
					0: c = CHAR_TAB;
					1: c = CHAR_BS;
					2: c = CHAR_CR;
					default: c = 8'($urandom_range(255));
				endcase
				send_item(put_word(c, k == len - 1 || $urandom_range(3) == 0));
			end
		end else if (pick < 95) begin
			len = $urandom_range(6, 1);
			for (int k = 0; k < len; k++) begin
				it.operation     = OP_READ;
				it.char_code     = 8'($urandom_range(255));
				it.end_of_string = 1'($urandom_range(1));
				case ($urandom_range(9))
					0, 1, 2: begin
						it.read_row    = 5'($urandom_range(31));
						it.read_column = 7'($urandom_range(127));
					end
					3, 4, 5: begin
						it.read_row    = 5'(cur_row);
						it.read_column = 7'($urandom_range(COLS - 1));
					end
					default: begin
						it.read_row    = 5'($urandom_range(ROWS - 1));
						it.read_column = 7'($urandom_range(COLS - 1));
					end
				endcase
				send_item(it);
			end
		end else if (pick < 97) begin
			send_item(put_word(CHAR_FF, 1'($urandom_range(1))));
		end else if (pick < 99) begin
			len = $urandom_range(4, 1);
			for (int k = 0; k < len; k++)
				send_item(tcw_in_t'($urandom));
		end else begin
			settle();
			if ($urandom_range(1))
				load_attrs(8'($urandom_range(255)), 8'($urandom_range(255)));
		end
	endtask

	task automatic run_phase(int unsigned quota, int unsigned gap_pct);
		int unsigned stop_at;
		stop_at = items_sent + quota;
		sender_gap_pct = gap_pct;
		while (items_sent < stop_at)
			emit_burst();
	endtask

	// Result checker
	always @(posedge clk) begin
		tcw_out_t want;
		if (arst_n && done) begin
			if (console_due.size() == 0) begin
				$error("result word with nothing expected: %h", result);
				fail_count++;
			end else begin
				want = console_due.pop_front();
				if (result.cursor_row !== want.cursor_row) begin
					$error("cursor_row expected %0d got %0d", want.cursor_row, result.cursor_row);
					fail_count++;
				end
				if (result.cursor_column !== want.cursor_column) begin
					$error("cursor_column expected %0d got %0d",
						want.cursor_column, result.cursor_column);
					fail_count++;
				end
				if (result.cursor_register !== want.cursor_register) begin
					$error("cursor_register expected %0d got %0d",
						want.cursor_register, result.cursor_register);
					fail_count++;
				end
				if (result.cell_value !== want.cell_value) begin
					$error("cell_value expected %h got %h", want.cell_value, result.cell_value);
					fail_count++;
				end
			end
		end
	end

	// Main sequence
	initial begin
		tcw_in_t it;
		blank_span(0, CELLS);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed table, reset attributes
		sender_gap_pct = 20;
		for (int i = 0; i < 24; i++) begin
			for (int n = 0; n < PLAN[i].reps; n++) begin
				it.operation     = PLAN[i].op;
				it.char_code     = PLAN[i].chr;
				it.end_of_string = PLAN[i].eos;
				it.read_row      = PLAN[i].rr;
				it.read_column   = PLAN[i].rc;
				send_item(it, PLAN[i].fixed && n == PLAN[i].reps - 1, PLAN[i].want);
			end
		end

		// random phases, attributes changed only when idle
		settle();
		load_attrs(8'h00, 8'hFF);
		run_phase(300, 32);
		settle();
		load_attrs(8'hFF, 8'h00);
		run_phase(300, 48);
		settle();
		load_attrs(8'($urandom_range(255)), 8'($urandom_range(255)));
		run_phase(300, 0);

		settle();
		repeat (16) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_text_console_writer_unit: PASS");
		end else begin
			$display("tb_text_console_writer_unit: FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#96_000_000;
		$display("tb_text_console_writer_unit: FAIL");
		$finish;
	end

endmodule
